FILE: src/sqlr_pkg.sv
// sqlr_pkg: shared constants and types for the special-q lattice reduction block
// no dependencies; imported by special_q_lattice_reduce
`default_nettype none

package sqlr_pkg;

   localparam int DEFAULT_COORD_WIDTH = 32;

   // field widths on the ports
   localparam int FIELD_BITS       = 32;
   localparam int OUT_BITS         = 33;
   localparam int SIEVE_WIDTH_BITS = 21;
   localparam int REQ_DATA_BITS    = 2 * FIELD_BITS;
   localparam int RSP_DATA_BITS    = ((4 * OUT_BITS + 7) / 8) * 8;

   localparam logic [SIEVE_WIDTH_BITS-1:0] SIEVE_WIDTH_RESET = SIEVE_WIDTH_BITS'(4096);

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_SHIFT = 6'b000100,
      ST_SUB   = 6'b001000,
      ST_APPLY = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // which reduction the divider is working on
   typedef enum logic [2:0] {
      OP_A   = 3'b001,
      OP_B   = 3'b010,
      OP_FIN = 3'b100
   } op_type;

endpackage

`default_nettype wire

FILE: src/special_q_lattice_reduce.sv
// special_q_lattice_reduce: top level, sequencer plus shared shift-subtract divider
// depends on sqlr_pkg
`default_nettype none

// Reduces the special-q lattice basis (p,0),(r,1) to (a0,a1),(b0,b1) with
// -I < a0 <= 0 <= b0 < I and b0 - a0 >= I, I being the sieve width register
// (zero is taken as one). A request carries modulus p and root r; one response
// comes back per request with ok and the four coordinates. When the divisor of
// the final correction step is zero, ok is low and the unreduced basis
// (p,0),(r,1) is returned. All coordinates leave as 33-bit two's complement.
// One request is worked on at a time; req_tready is high only while the engine
// is idle, and a finished response waits in an output register so the engine
// can take the next request meanwhile. Every Euclid step and the final
// correction go through one shift-subtract divider that also accumulates the
// quotient times a coefficient. A division first lines the divisor up under the
// numerator in ST_SHIFT, then takes the quotient bits msb first in ST_SUB, and
// ST_APPLY stores the new coordinate and coefficient of a Euclid step; ST_CHECK
// picks the next division or the correction step, and ST_OUT loads the response.
// The divider's compare-subtract of NW bits, the larger of COORD_WIDTH+1 and
// SIEVE_WIDTH_BITS+1, sets the clock.
module special_q_lattice_reduce
   import sqlr_pkg::*;
#(
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request: modulus [31:0], root [63:32]
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]    req_tdata,
   // response: first_x [32:0], first_y [65:33], second_x [98:66],
   // second_y [131:99], zero fill above
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [RSP_DATA_BITS-1:0]         rsp_tdata,
   // response user: ok [0]
   output logic                             rsp_tuser,
   // sieve width register
   input  wire logic                        csr_wr_en,
   input  wire logic [SIEVE_WIDTH_BITS-1:0] csr_wr_data
);

   // divider magnitude width: coordinate sums and the sieve width must fit
   localparam int NW   = (COORD_WIDTH + 1 > SIEVE_WIDTH_BITS + 1) ?
                         COORD_WIDTH + 1 : SIEVE_WIDTH_BITS + 1;
   // coefficient width: exact in the loop, at least the output width for wrap
   localparam int CFW  = (COORD_WIDTH + 1 > OUT_BITS) ? COORD_WIDTH + 1 : OUT_BITS;
   // width for the final x coordinate arithmetic
   localparam int XW   = (NW + 2 > OUT_BITS) ? NW + 2 : OUT_BITS;
   // width to pick coordinates out of the 32-bit request fields
   localparam int EW   = (COORD_WIDTH > FIELD_BITS) ? COORD_WIDTH : FIELD_BITS;
   localparam int CNTW = $clog2(NW);

   // control registers
   state_type                   state_ff, state_in;
   logic [SIEVE_WIDTH_BITS-1:0] sieve_width_ff, sieve_width_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // working registers
   op_type                      op_ff, op_in;
   logic [COORD_WIDTH-1:0]      p_ff, p_in, r_ff, r_in;
   logic [COORD_WIDTH-1:0]      am_ff, am_in, bm_ff, bm_in;   // |a0| and b0
   logic [CFW-1:0]              a1_ff, a1_in, b1_ff, b1_in;
   logic [NW-1:0]               num_ff, num_in, dsh_ff, dsh_in;
   logic [CNTW-1:0]             cnt_ff, cnt_in;
   logic [CFW-1:0]              acc_ff, acc_in;
   logic                        fin_a_ff, fin_a_in;           // correction on b, divisor a0
   logic                        kneg_ff, kneg_in;             // sign of final quotient
   logic                        kmin_ff, kmin_in;             // sign of final numerator
   logic                        fail_ff, fail_in;

   // response registers
   logic                        ok_ff, ok_in;
   logic [OUT_BITS-1:0]         fx_ff, fx_in, fy_ff, fy_in, sx_ff, sx_in, sy_ff, sy_in;

   // request fields
   logic [EW-1:0]               mod_ext, root_ext;

   // datapath
   logic [NW-1:0]               hi_w, am_x, bm_x;
   logic                        a_small, b_small, fin_a, fin_zero;
   logic [NW:0]                 k_w;
   logic                        k_neg;
   logic [NW:0]                 k_abs;
   logic [CFW-1:0]              coef;
   logic [NW:0]                 dbl;
   logic                        shift_ok, ge;
   logic [CFW-1:0]              acc_next;
   logic [XW-1:0]               rem_x, rs, hi_xx, am_xx, bm_xx;
   logic [XW-1:0]               fx_w, sx_w;
   logic [CFW-1:0]              fy_w, sy_w;

   assign mod_ext  = EW'(req_tdata[FIELD_BITS-1:0]);
   assign root_ext = EW'(req_tdata[REQ_DATA_BITS-1:FIELD_BITS]);

   // effective sieve width, zero taken as one
   assign hi_w = (sieve_width_ff == '0) ? NW'(1) : NW'(sieve_width_ff);
   assign am_x = NW'(am_ff);
   assign bm_x = NW'(bm_ff);

   // loop exit tests
   assign a_small = am_x < hi_w;
   assign b_small = bm_x < hi_w;

   // final step: K = b0 - I - a0, and which vector gets corrected
   assign k_w      = {1'b0, bm_x} + {1'b0, am_x} - {1'b0, hi_w};
   assign k_neg    = k_w[NW];
   assign k_abs    = k_neg ? (~k_w + (NW+1)'(1)) : k_w;
   assign fin_a    = bm_x > am_x;
   assign fin_zero = fin_a ? (am_ff == '0) : (bm_ff == '0);

   // coefficient multiplied by the quotient
   always_comb begin
      case (op_ff)
         OP_A:    coef = b1_ff;
         OP_B:    coef = a1_ff;
         OP_FIN:  coef = fin_a_ff ? a1_ff : b1_ff;
         default: coef = '0;
      endcase
   end

   // shared shift-subtract unit
   assign dbl      = {dsh_ff, 1'b0};
   assign shift_ok = dbl <= {1'b0, num_ff};
   assign ge       = num_ff >= dsh_ff;
   // quotient bits come msb first, so the product builds up in horner form
   assign acc_next = {acc_ff[CFW-2:0], 1'b0} + (ge ? coef : '0);

   // final result: k*d is K minus the truncated remainder
   assign rem_x = XW'(num_ff);
   assign rs    = kmin_ff ? (XW'(0) - rem_x) : rem_x;
   assign hi_xx = XW'(hi_w);
   assign am_xx = XW'(am_ff);
   assign bm_xx = XW'(bm_ff);

   always_comb begin
      if (fail_ff) begin
         fx_w = XW'(p_ff);
         fy_w = '0;
         sx_w = XW'(r_ff);
         sy_w = CFW'(1);
      end else if (fin_a_ff) begin
         // b -= k*a
         fx_w = XW'(0) - am_xx;
         fy_w = a1_ff;
         sx_w = hi_xx - am_xx + rs;
         sy_w = kneg_ff ? (b1_ff + acc_ff) : (b1_ff - acc_ff);
      end else begin
         // a += k*b
         fx_w = bm_xx - hi_xx - rs;
         fy_w = kneg_ff ? (a1_ff - acc_ff) : (a1_ff + acc_ff);
         sx_w = bm_xx;
         sy_w = b1_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      sieve_width_in = csr_wr_en ? csr_wr_data : sieve_width_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      op_in          = op_ff;
      p_in           = p_ff;
      r_in           = r_ff;
      am_in          = am_ff;
      bm_in          = bm_ff;
      a1_in          = a1_ff;
      b1_in          = b1_ff;
      num_in         = num_ff;
      dsh_in         = dsh_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      fin_a_in       = fin_a_ff;
      kneg_in        = kneg_ff;
      kmin_in        = kmin_ff;
      fail_in        = fail_ff;
      ok_in          = ok_ff;
      fx_in          = fx_ff;
      fy_in          = fy_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               p_in     = mod_ext[COORD_WIDTH-1:0];
               r_in     = root_ext[COORD_WIDTH-1:0];
               am_in    = mod_ext[COORD_WIDTH-1:0];
               bm_in    = root_ext[COORD_WIDTH-1:0];
               a1_in    = '0;
               b1_in    = CFW'(1);
               // pretend b was just reduced so the first test is on b0
               op_in    = OP_B;
               fail_in  = 1'b0;
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            acc_in = '0;
            cnt_in = '0;
            if ((op_ff == OP_B && b_small) || (op_ff == OP_A && a_small)) begin
               // loop done, set up the correction step
               if (fin_zero) begin
                  fail_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  num_in   = k_abs[NW-1:0];
                  dsh_in   = fin_a ? am_x : bm_x;
                  kmin_in  = k_neg;
                  kneg_in  = fin_a ? !k_neg : k_neg;
                  fin_a_in = fin_a;
                  op_in    = OP_FIN;
                  state_in = ST_SHIFT;
               end
            end else if (op_ff == OP_B) begin
               // reduce a0 by b0
               num_in   = am_x;
               dsh_in   = bm_x;
               op_in    = OP_A;
               state_in = ST_SHIFT;
            end else begin
               // reduce b0 by a0
               num_in   = bm_x;
               dsh_in   = am_x;
               op_in    = OP_B;
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // line the divisor up under the numerator's top bit
            if (shift_ok) begin
               dsh_in = dbl[NW-1:0];
               cnt_in = cnt_ff + CNTW'(1);
            end else begin
               state_in = ST_SUB;
            end
         end

         ST_SUB: begin
            if (ge) begin
               num_in = num_ff - dsh_ff;
            end
            acc_in = acc_next;
            if (cnt_ff == '0) begin
               state_in = ST_APPLY;
            end else begin
               dsh_in = {1'b0, dsh_ff[NW-1:1]};
               cnt_in = cnt_ff - CNTW'(1);
            end
         end

         ST_APPLY: begin
            case (op_ff)
               OP_A: begin
                  am_in    = num_ff[COORD_WIDTH-1:0];
                  a1_in    = a1_ff + acc_ff;
                  state_in = ST_CHECK;
               end
               OP_B: begin
                  bm_in    = num_ff[COORD_WIDTH-1:0];
                  b1_in    = b1_ff + acc_ff;
                  state_in = ST_CHECK;
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end

         ST_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               ok_in        = !fail_ff;
               fx_in        = fx_w[OUT_BITS-1:0];
               fy_in        = fy_w[OUT_BITS-1:0];
               sx_in        = sx_w[OUT_BITS-1:0];
               sy_in        = sy_w[OUT_BITS-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sieve_width_ff <= SIEVE_WIDTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sieve_width_ff <= sieve_width_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      p_ff     <= p_in;
      r_ff     <= r_in;
      am_ff    <= am_in;
      bm_ff    <= bm_in;
      a1_ff    <= a1_in;
      b1_ff    <= b1_in;
      num_ff   <= num_in;
      dsh_ff   <= dsh_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      fin_a_ff <= fin_a_in;
      kneg_ff  <= kneg_in;
      kmin_ff  <= kmin_in;
      fail_ff  <= fail_in;
      ok_ff    <= ok_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({sy_ff, sx_ff, fy_ff, fx_ff});

`ifndef ASSERT_OFF
   // the divider never runs with a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB) |-> (dsh_ff != '0))
      else $error("divider running with zero divisor");

   // the remainder left by a division is below its divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> (num_ff < dsh_ff))
      else $error("remainder not below divisor");

   // a response only appears out of the output-load state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside output load");
`endif

endmodule

`default_nettype wire
